// ===== rtl/lcc_pkg.sv =====
// shared constants, types and lookup tables for the linear coil commutation core
package lcc_pkg;

   // field and datapath widths
   localparam int CODE_W         = 12;
   localparam int SERIES_W       = 16;
   localparam int DIV_W          = 16;
   localparam int PROD_W         = CODE_W + SERIES_W;
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = (PROD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int QUO_W          = DIV_STAGES * BITS_PER_STAGE;
   localparam int TRAVEL_W       = QUO_W + 1;
   localparam int ZONE_W         = 4;
   localparam int DUTY_W         = 8;
   localparam int NUM_COILS      = 6;
   localparam int NUM_BOUNDS     = 14;
   localparam int NUM_ZONES      = 13;

   // input register, multiply, divide stages, travel compare, output register
   localparam int LATENCY = DIV_STAGES + 4;

   // default full-scale code of the converter
   localparam int unsigned ADC_FULL_SCALE_DEF = 4095;

   // control and status register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_CODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERIES_OHMS    = 2'd1;

   localparam logic [CODE_W-1:0]   REFERENCE_CODE_RESET = 12'd1643;
   localparam logic [SERIES_W-1:0] SERIES_OHMS_RESET    = 16'd1000;

   localparam logic [ZONE_W-1:0] DEFAULT_ZONE = 4'd14;

   localparam logic [DUTY_W-1:0] DUTY_LO  = 8'h60;
   localparam logic [DUTY_W-1:0] DUTY_MID = 8'h80;
   localparam logic [DUTY_W-1:0] DUTY_HI  = 8'hA0;

   typedef logic signed [TRAVEL_W-1:0] travel_type;

   // coil one sits in the top byte, coil six in the bottom byte
   typedef logic [NUM_COILS-1:0][DUTY_W-1:0] duty_set_type;

   typedef struct packed {
      logic valid;
      logic fault;
   } ctrl_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] dvd;
   } div_lane_type;

   // zone bounds in ohms, millimetres times 40
   localparam travel_type BOUNDS [NUM_BOUNDS] = '{
      travel_type'(1920), travel_type'(2032), travel_type'(2880), travel_type'(2992),
      travel_type'(3840), travel_type'(3952), travel_type'(4064), travel_type'(4800),
      travel_type'(4912), travel_type'(5040), travel_type'(5872), travel_type'(5984),
      travel_type'(6832), travel_type'(6944)
   };

   // duty bytes per zone, coils one to six
   localparam duty_set_type DUTY_TABLE [NUM_ZONES] = '{
      {DUTY_MID, DUTY_HI,  DUTY_MID, DUTY_MID, DUTY_MID, DUTY_MID},
      {DUTY_LO,  DUTY_HI,  DUTY_MID, DUTY_MID, DUTY_MID, DUTY_MID},
      {DUTY_LO,  DUTY_HI,  DUTY_MID, DUTY_MID, DUTY_HI,  DUTY_MID},
      {DUTY_LO,  DUTY_HI,  DUTY_MID, DUTY_LO,  DUTY_HI,  DUTY_MID},
      {DUTY_LO,  DUTY_HI,  DUTY_HI,  DUTY_LO,  DUTY_HI,  DUTY_MID},
      {DUTY_LO,  DUTY_LO,  DUTY_HI,  DUTY_LO,  DUTY_HI,  DUTY_MID},
      {DUTY_MID, DUTY_LO,  DUTY_HI,  DUTY_LO,  DUTY_HI,  DUTY_MID},
      {DUTY_MID, DUTY_LO,  DUTY_HI,  DUTY_LO,  DUTY_HI,  DUTY_HI},
      {DUTY_MID, DUTY_LO,  DUTY_HI,  DUTY_LO,  DUTY_LO,  DUTY_HI},
      {DUTY_MID, DUTY_LO,  DUTY_HI,  DUTY_MID, DUTY_LO,  DUTY_HI},
      {DUTY_MID, DUTY_LO,  DUTY_MID, DUTY_MID, DUTY_LO,  DUTY_HI},
      {DUTY_MID, DUTY_MID, DUTY_MID, DUTY_MID, DUTY_LO,  DUTY_HI},
      {DUTY_MID, DUTY_MID, DUTY_MID, DUTY_MID, DUTY_LO,  DUTY_MID}
   };

endpackage

// ===== rtl/lcc_div_stage.sv =====
// one registered stage of the restoring divider, both resistance lanes
module lcc_div_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  lcc_pkg::ctrl_type              in_ctrl,
   input  lcc_pkg::div_lane_type          in_val,
   input  lcc_pkg::div_lane_type          in_ref,
   input  logic [lcc_pkg::DIV_W-1:0]      in_div_val,
   input  logic [lcc_pkg::DIV_W-1:0]      in_div_ref,
   output lcc_pkg::ctrl_type              out_ctrl,
   output lcc_pkg::div_lane_type          out_val,
   output lcc_pkg::div_lane_type          out_ref,
   output logic [lcc_pkg::DIV_W-1:0]      out_div_val,
   output logic [lcc_pkg::DIV_W-1:0]      out_div_ref
);

   lcc_pkg::ctrl_type              ctrl_ff;
   lcc_pkg::div_lane_type          val_ff, val_in;
   lcc_pkg::div_lane_type          ref_ff, ref_in;
   logic [lcc_pkg::DIV_W-1:0]      div_val_ff, div_ref_ff;

   // four quotient bits, shift-subtract, quotient fills the dividend from the bottom
   function automatic lcc_pkg::div_lane_type div_bits(
      input lcc_pkg::div_lane_type lane,
      input logic [lcc_pkg::DIV_W-1:0] divisor
   );
      lcc_pkg::div_lane_type cur;
      logic [lcc_pkg::DIV_W:0] trial;
      cur = lane;
      for (int i = 0; i < lcc_pkg::BITS_PER_STAGE; i++) begin
         trial   = {cur.rem, cur.dvd[lcc_pkg::QUO_W-1]};
         cur.dvd = {cur.dvd[lcc_pkg::QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial      = trial - {1'b0, divisor};
            cur.dvd[0] = 1'b1;
         end
         cur.rem = trial[lcc_pkg::DIV_W-1:0];
      end
      return cur;
   endfunction

   // next lane values
   always_comb begin
      val_in = div_bits(in_val, in_div_val);
      ref_in = div_bits(in_ref, in_div_ref);
   end

   // valid and fault bits
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= in_ctrl;
      end
   end

   // lane payload
   always_ff @(posedge clock) begin
      val_ff     <= val_in;
      ref_ff     <= ref_in;
      div_val_ff <= in_div_val;
      div_ref_ff <= in_div_ref;
   end

   assign out_ctrl    = ctrl_ff;
   assign out_val     = val_ff;
   assign out_ref     = ref_ff;
   assign out_div_val = div_val_ff;
   assign out_div_ref = div_ref_ff;

endmodule

// ===== rtl/lcc_zone_map.sv =====
// travel from the two resistances, zone search against the bounds and duty lookup
module lcc_zone_map (
   input  logic                              clock,
   input  logic                              reset,
   input  lcc_pkg::ctrl_type                 in_ctrl,
   input  logic [lcc_pkg::QUO_W-1:0]         in_ohms_val,
   input  logic [lcc_pkg::QUO_W-1:0]         in_ohms_ref,
   output logic                              out_valid,
   output lcc_pkg::duty_set_type             out_duty,
   output logic [lcc_pkg::ZONE_W-1:0]        out_zone,
   output logic                              out_fault
);

   lcc_pkg::travel_type                 travel;
   logic [lcc_pkg::NUM_BOUNDS-1:0]      ge_in, ge_ff;
   lcc_pkg::ctrl_type                   ctrl_ff;
   logic [lcc_pkg::ZONE_W-1:0]          zone_in, zone_ff;
   lcc_pkg::duty_set_type               duty_in, duty_ff;
   logic                                valid_ff, fault_ff;

   // travel and one compare per bound
   always_comb begin
      travel = lcc_pkg::travel_type'({1'b0, in_ohms_val})
             - lcc_pkg::travel_type'({1'b0, in_ohms_ref});
      for (int b = 0; b < lcc_pkg::NUM_BOUNDS; b++) begin
         ge_in[b] = (travel >= lcc_pkg::BOUNDS[b]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= in_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      ge_ff <= ge_in;
   end

   // bounds ascend, so at most one interval matches
   always_comb begin
      zone_in = lcc_pkg::DEFAULT_ZONE;
      duty_in = {lcc_pkg::NUM_COILS{lcc_pkg::DUTY_MID}};
      for (int z = 0; z < lcc_pkg::NUM_ZONES; z++) begin
         if (!ctrl_ff.fault && ge_ff[z] && !ge_ff[z+1]) begin
            zone_in = lcc_pkg::ZONE_W'(z);
            duty_in = lcc_pkg::DUTY_TABLE[z];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      zone_ff  <= zone_in;
      duty_ff  <= duty_in;
      fault_ff <= ctrl_ff.fault;
   end

   assign out_valid = valid_ff;
   assign out_duty  = duty_ff;
   assign out_zone  = zone_ff;
   assign out_fault = fault_ff;

endmodule

// ===== rtl/linear_coil_commutation_core.sv =====
// top level of the linear coil commutation core
//
// Usage: pulse start with a 12-bit potentiometer code on req_adc_code while
// busy is low; the code is taken at that clock edge. A new code may be given
// in every cycle. Each code yields one result: six coil duty bytes, the zone
// and divide_fault, shown for one cycle with rsp_valid high. A code passes
// through the input register, the multiply stage with its two multipliers,
// seven divider stages of four quotient bits each, the travel compare and
// the output register before its result is on the rsp_ ports. Throughput
// is one code per clock while busy is low, set by the fully pipelined divider
// lanes; the reference resistance is divided again alongside every code.
// Registers reference_code (index 0) and series_ohms (index 1) are written
// over the csr_ channel, which is always ready; write them only while no
// code is in flight.
// Reset is synchronous: it empties the pipeline, drops rsp_valid, loads the
// register defaults and holds busy high for the cycle after it. The receiver
// cannot stall; results are never held back.
module linear_coil_commutation_core #(
   parameter int unsigned ADC_FULL_SCALE = lcc_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lcc_pkg::CODE_W-1:0]         req_adc_code,
   output logic                               rsp_valid,
   output logic [lcc_pkg::DUTY_W-1:0]         rsp_coil1_duty,
   output logic [lcc_pkg::DUTY_W-1:0]         rsp_coil2_duty,
   output logic [lcc_pkg::DUTY_W-1:0]         rsp_coil3_duty,
   output logic [lcc_pkg::DUTY_W-1:0]         rsp_coil4_duty,
   output logic [lcc_pkg::DUTY_W-1:0]         rsp_coil5_duty,
   output logic [lcc_pkg::DUTY_W-1:0]         rsp_coil6_duty,
   output logic [lcc_pkg::ZONE_W-1:0]         rsp_zone,
   output logic                               rsp_divide_fault,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [lcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lcc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [lcc_pkg::DIV_W-1:0] FULL_SCALE = lcc_pkg::DIV_W'(ADC_FULL_SCALE);

   logic                              busy_ff;
   logic                              accept;
   logic [lcc_pkg::CODE_W-1:0]        reference_code_ff;
   logic [lcc_pkg::SERIES_W-1:0]      series_ohms_ff;

   lcc_pkg::ctrl_type                 s0_ctrl_in, s0_ctrl_ff;
   logic [lcc_pkg::CODE_W-1:0]        s0_code_ff, s0_ref_ff;
   logic [lcc_pkg::SERIES_W-1:0]      s0_series_ff;
   logic [lcc_pkg::DIV_W-1:0]         s0_div_val_in, s0_div_val_ff;
   logic [lcc_pkg::DIV_W-1:0]         s0_div_ref_in, s0_div_ref_ff;

   lcc_pkg::div_lane_type             mul_val_in, mul_ref_in;

   lcc_pkg::ctrl_type                 dv_ctrl    [lcc_pkg::DIV_STAGES+1];
   lcc_pkg::div_lane_type             dv_val     [lcc_pkg::DIV_STAGES+1];
   lcc_pkg::div_lane_type             dv_ref     [lcc_pkg::DIV_STAGES+1];
   logic [lcc_pkg::DIV_W-1:0]         dv_div_val [lcc_pkg::DIV_STAGES+1];
   logic [lcc_pkg::DIV_W-1:0]         dv_div_ref [lcc_pkg::DIV_STAGES+1];

   lcc_pkg::duty_set_type             duty;

   // handshake
   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reference_code_ff <= lcc_pkg::REFERENCE_CODE_RESET;
         series_ohms_ff    <= lcc_pkg::SERIES_OHMS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lcc_pkg::CSR_REFERENCE_CODE: begin
               reference_code_ff <= csr_wdata[lcc_pkg::CODE_W-1:0];
            end
            lcc_pkg::CSR_SERIES_OHMS: begin
               series_ohms_ff <= csr_wdata[lcc_pkg::SERIES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input stage: divisor and zero-divisor check for both lanes
   always_comb begin
      s0_div_val_in    = FULL_SCALE - lcc_pkg::DIV_W'(req_adc_code);
      s0_div_ref_in    = FULL_SCALE - lcc_pkg::DIV_W'(reference_code_ff);
      s0_ctrl_in.valid = accept;
      s0_ctrl_in.fault = (lcc_pkg::DIV_W'(req_adc_code) >= FULL_SCALE)
                      || (lcc_pkg::DIV_W'(reference_code_ff) >= FULL_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctrl_ff <= '0;
      end else begin
         s0_ctrl_ff <= s0_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_code_ff    <= req_adc_code;
      s0_ref_ff     <= reference_code_ff;
      s0_series_ff  <= series_ohms_ff;
      s0_div_val_ff <= s0_div_val_in;
      s0_div_ref_ff <= s0_div_ref_in;
   end

   // multiply stage: the input and reference codes times the series resistor feed the divider
   always_comb begin
      mul_val_in.rem = '0;
      mul_val_in.dvd = lcc_pkg::QUO_W'(s0_code_ff * s0_series_ff);
      mul_ref_in.rem = '0;
      mul_ref_in.dvd = lcc_pkg::QUO_W'(s0_ref_ff * s0_series_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ctrl[0] <= '0;
      end else begin
         dv_ctrl[0] <= s0_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      dv_val[0]     <= mul_val_in;
      dv_ref[0]     <= mul_ref_in;
      dv_div_val[0] <= s0_div_val_ff;
      dv_div_ref[0] <= s0_div_ref_ff;
   end

   // divider pipeline
   for (genvar s = 0; s < lcc_pkg::DIV_STAGES; s++) begin : g_div
      lcc_div_stage u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_ctrl     (dv_ctrl[s]),
         .in_val      (dv_val[s]),
         .in_ref      (dv_ref[s]),
         .in_div_val  (dv_div_val[s]),
         .in_div_ref  (dv_div_ref[s]),
         .out_ctrl    (dv_ctrl[s+1]),
         .out_val     (dv_val[s+1]),
         .out_ref     (dv_ref[s+1]),
         .out_div_val (dv_div_val[s+1]),
         .out_div_ref (dv_div_ref[s+1])
      );
   end

   // travel, zone and duty
   lcc_zone_map u_zone_map (
      .clock       (clock),
      .reset       (reset),
      .in_ctrl     (dv_ctrl[lcc_pkg::DIV_STAGES]),
      .in_ohms_val (dv_val[lcc_pkg::DIV_STAGES].dvd),
      .in_ohms_ref (dv_ref[lcc_pkg::DIV_STAGES].dvd),
      .out_valid   (rsp_valid),
      .out_duty    (duty),
      .out_zone    (rsp_zone),
      .out_fault   (rsp_divide_fault)
   );

   assign rsp_coil1_duty = duty[5];
   assign rsp_coil2_duty = duty[4];
   assign rsp_coil3_duty = duty[3];
   assign rsp_coil4_duty = duty[2];
   assign rsp_coil5_duty = duty[1];
   assign rsp_coil6_duty = duty[0];

endmodule

// ===== rtl/lcc_checker.sv =====
// port-level checks for the linear coil commutation core, bound to the top level
module lcc_checker #(
   parameter int unsigned ADC_FULL_SCALE = lcc_pkg::ADC_FULL_SCALE_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [lcc_pkg::CODE_W-1:0]        req_adc_code,
   input logic                              rsp_valid,
   input logic [lcc_pkg::DUTY_W-1:0]        rsp_coil1_duty,
   input logic [lcc_pkg::DUTY_W-1:0]        rsp_coil6_duty,
   input logic [lcc_pkg::ZONE_W-1:0]        rsp_zone,
   input logic                              rsp_divide_fault
);

   localparam logic [lcc_pkg::DIV_W-1:0] FULL_SCALE = lcc_pkg::DIV_W'(ADC_FULL_SCALE);

   // every transfer in gives a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(lcc_pkg::LATENCY) rsp_valid)
      else $error("result missing after input transfer");

   // a code at or above full scale comes back flagged
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (lcc_pkg::DIV_W'(req_adc_code) >= FULL_SCALE))
      |-> ##(lcc_pkg::LATENCY) rsp_divide_fault)
      else $error("full-scale code not flagged");

   // a flagged result is the default zone with middle duty on coils one and six
   a_fault_default: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_fault) |-> (rsp_zone == lcc_pkg::DEFAULT_ZONE
         && rsp_coil1_duty == lcc_pkg::DUTY_MID && rsp_coil6_duty == lcc_pkg::DUTY_MID))
      else $error("flagged result not in default zone");

   // zones thirteen and fifteen are never produced
   a_zone_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zone < 4'd13 || rsp_zone == lcc_pkg::DEFAULT_ZONE))
      else $error("zone out of range");

endmodule

bind linear_coil_commutation_core lcc_checker #(
   .ADC_FULL_SCALE (ADC_FULL_SCALE)
) u_lcc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_adc_code     (req_adc_code),
   .rsp_valid        (rsp_valid),
   .rsp_coil1_duty   (rsp_coil1_duty),
   .rsp_coil6_duty   (rsp_coil6_duty),
   .rsp_zone         (rsp_zone),
   .rsp_divide_fault (rsp_divide_fault)
);
